// ===== src/ffs_pkg.sv =====
// ============================================================================
// ffs_pkg - flight failsafe supervisor shared definitions
// Word layouts, command and reason codes, config register indexes and the
// fixed reason-to-action map.
// ============================================================================
package ffs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 32;

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAUNCH_TIMEOUT    = 3'd0,
        CFG_APOGEE_TIMEOUT    = 3'd1,
        CFG_STABILIZE_TIMEOUT = 3'd2,
        CFG_MAX_FLIGHT_TIME   = 3'd3,
        CFG_SERVO_TIMEOUT     = 3'd4,
        CFG_RECOVERY_DELAY    = 3'd5,
        CFG_AUTO_RECOVER      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Reason codes
    localparam logic [3:0] RSN_NONE       = 4'd0;
    localparam logic [3:0] RSN_IMU        = 4'd1;
    localparam logic [3:0] RSN_BARO       = 4'd2;
    localparam logic [3:0] RSN_GPS        = 4'd3;
    localparam logic [3:0] RSN_SERVO      = 4'd4;
    localparam logic [3:0] RSN_MEM        = 4'd5;
    localparam logic [3:0] RSN_CPU        = 4'd6;
    localparam logic [3:0] RSN_WATCHDOG   = 4'd8;
    localparam logic [3:0] RSN_MANUAL     = 4'd9;
    localparam logic [3:0] RSN_LAUNCH     = 4'd10;
    localparam logic [3:0] RSN_APOGEE     = 4'd11;
    localparam logic [3:0] RSN_STABILIZE  = 4'd12;
    localparam logic [3:0] RSN_GUIDANCE   = 4'd13;
    localparam logic [3:0] RSN_FLIGHTTIME = 4'd14;
    localparam logic [3:0] RSN_POWER      = 4'd15;

    // Action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_NEUTRAL = 3'd1;
    localparam logic [2:0] ACT_FLARE   = 3'd2;
    localparam logic [2:0] ACT_SPIRAL  = 3'd3;
    localparam logic [2:0] ACT_CUTOFF  = 3'd4;
    localparam logic [2:0] ACT_REBOOT  = 3'd5;

    localparam logic [1:0] HEALTH_OK     = 2'd0;
    localparam logic [1:0] HEALTH_FAILED = 2'd2;

    localparam logic [2:0] PH_ARMED     = 3'd1;
    localparam logic [2:0] PH_ASCENT    = 3'd2;
    localparam logic [2:0] PH_APOGEE    = 3'd3;
    localparam logic [2:0] PH_STABILIZE = 3'd4;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] now_ms;
        logic [2:0]        flight_phase;
        logic [TIME_W-1:0] armed_time;
        logic [TIME_W-1:0] launch_time;
        logic [TIME_W-1:0] stabilize_start;
        logic [TIME_W-1:0] servo_update_time;
        logic [7:0]        subsystem_health;
        logic [1:0]        resource_flags;
        logic [3:0]        trigger_reason;
    } in_word_t;

    typedef struct packed {
        logic              failsafe_active;
        logic [3:0]        active_reason;
        logic [2:0]        active_action;
        logic              reboot_required;
        logic [TIME_W-1:0] trigger_time;
    } out_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] launch_timeout;
        logic [TIME_W-1:0] apogee_timeout;
        logic [TIME_W-1:0] stabilize_timeout;
        logic [TIME_W-1:0] max_flight_time;
        logic [TIME_W-1:0] servo_timeout;
        logic [TIME_W-1:0] recovery_delay;
        logic              auto_recover_enable;
    } cfg_t;

    typedef struct packed {
        logic              latched;
        logic [3:0]        reason;
        logic [2:0]        action;
        logic              reboot;
        logic [TIME_W-1:0] latch_time;
    } fs_state_t;

    function automatic logic [2:0] action_for(input logic [3:0] reason);
        logic [2:0] act;
        unique case (reason)
            RSN_SERVO:                                          act = ACT_CUTOFF;
            RSN_MEM, RSN_CPU, RSN_WATCHDOG:                     act = ACT_REBOOT;
            RSN_LAUNCH, RSN_APOGEE, RSN_FLIGHTTIME, RSN_POWER:  act = ACT_FLARE;
            RSN_STABILIZE, RSN_GUIDANCE:                        act = ACT_SPIRAL;
            default:                                            act = ACT_NEUTRAL;
        endcase
        return act;
    endfunction

    function automatic logic needs_reboot(input logic [3:0] reason);
        return (reason == RSN_MEM) || (reason == RSN_CPU) || (reason == RSN_WATCHDOG);
    endfunction

endpackage

// ===== src/ffs_cfg_regs.sv =====
// ============================================================================
// ffs_cfg_regs - configuration register file
// Write-only timeout/delay registers and the auto-recover enable, all cleared by reset.
// ============================================================================
module ffs_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ffs_pkg::cfg_t                    cfg
);

    ffs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (ffs_pkg::cfg_idx_t'(cfg_index))
                ffs_pkg::CFG_LAUNCH_TIMEOUT:    cfg_reg.launch_timeout    <= cfg_wdata;
                ffs_pkg::CFG_APOGEE_TIMEOUT:    cfg_reg.apogee_timeout    <= cfg_wdata;
                ffs_pkg::CFG_STABILIZE_TIMEOUT: cfg_reg.stabilize_timeout <= cfg_wdata;
                ffs_pkg::CFG_MAX_FLIGHT_TIME:   cfg_reg.max_flight_time   <= cfg_wdata;
                ffs_pkg::CFG_SERVO_TIMEOUT:     cfg_reg.servo_timeout     <= cfg_wdata;
                ffs_pkg::CFG_RECOVERY_DELAY:    cfg_reg.recovery_delay    <= cfg_wdata;
                ffs_pkg::CFG_AUTO_RECOVER:      cfg_reg.auto_recover_enable <= cfg_wdata[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/ffs_eval.sv =====
// ============================================================================
// ffs_eval - failsafe decision logic
// Runs the prioritized health/timeout checks for one word and computes the
// next latch state from the command.
// ============================================================================
module ffs_eval (
    input  ffs_pkg::in_word_t    in_word,
    input  ffs_pkg::cfg_t        cfg,
    input  ffs_pkg::fs_state_t   state,
    output ffs_pkg::fs_state_t   state_next
);

    logic [ffs_pkg::TIME_W-1:0] dt_armed, dt_launch, dt_stab, dt_servo, dt_latch;
    logic [1:0] h_imu, h_baro, h_gps, h_servo;
    logic       ph_pre, ph_asc, ph_stab, ph_post;
    logic       to_launch, to_apogee, to_stab, to_flight, to_servo;
    logic       all_good, recover;
    logic [3:0] fail_reason;
    ffs_pkg::fs_state_t latch_new, unlatched;

    // wrap-around elapsed times
    assign dt_armed  = in_word.now_ms - in_word.armed_time;
    assign dt_launch = in_word.now_ms - in_word.launch_time;
    assign dt_stab   = in_word.now_ms - in_word.stabilize_start;
    assign dt_servo  = in_word.now_ms - in_word.servo_update_time;
    assign dt_latch  = in_word.now_ms - state.latch_time;

    assign h_imu   = in_word.subsystem_health[1:0];
    assign h_baro  = in_word.subsystem_health[3:2];
    assign h_gps   = in_word.subsystem_health[5:4];
    assign h_servo = in_word.subsystem_health[7:6];

    assign ph_pre  = in_word.flight_phase <= ffs_pkg::PH_ARMED;
    assign ph_asc  = (in_word.flight_phase == ffs_pkg::PH_ASCENT) ||
                     (in_word.flight_phase == ffs_pkg::PH_APOGEE);
    assign ph_stab = in_word.flight_phase == ffs_pkg::PH_STABILIZE;
    assign ph_post = in_word.flight_phase >= ffs_pkg::PH_ASCENT;

    assign to_launch = ph_pre  && (dt_armed  >= cfg.launch_timeout);
    assign to_apogee = ph_asc  && (dt_launch >= cfg.apogee_timeout);
    assign to_stab   = ph_stab && (dt_stab   >= cfg.stabilize_timeout);
    assign to_flight = ph_post && (dt_launch >= cfg.max_flight_time);
    // zero timestamp means the servo was never updated
    assign to_servo  = (in_word.servo_update_time != '0) && (dt_servo >= cfg.servo_timeout);

    always_comb begin
        priority if (h_imu == ffs_pkg::HEALTH_FAILED)   fail_reason = ffs_pkg::RSN_IMU;
        else if (h_baro == ffs_pkg::HEALTH_FAILED)      fail_reason = ffs_pkg::RSN_BARO;
        else if (h_gps == ffs_pkg::HEALTH_FAILED)       fail_reason = ffs_pkg::RSN_GPS;
        else if (h_servo == ffs_pkg::HEALTH_FAILED)     fail_reason = ffs_pkg::RSN_SERVO;
        else if (in_word.resource_flags[0])             fail_reason = ffs_pkg::RSN_MEM;
        else if (in_word.resource_flags[1])             fail_reason = ffs_pkg::RSN_CPU;
        else if (to_launch)                             fail_reason = ffs_pkg::RSN_LAUNCH;
        else if (to_apogee)                             fail_reason = ffs_pkg::RSN_APOGEE;
        else if (to_stab)                               fail_reason = ffs_pkg::RSN_STABILIZE;
        else if (to_flight)                             fail_reason = ffs_pkg::RSN_FLIGHTTIME;
        else if (to_servo)                              fail_reason = ffs_pkg::RSN_SERVO;
        else                                            fail_reason = ffs_pkg::RSN_NONE;
    end

    // health code 3 is not "good", so any nonzero code blocks recovery
    assign all_good = (in_word.subsystem_health == {4{ffs_pkg::HEALTH_OK}}) &&
                      (in_word.resource_flags == 2'b00);
    assign recover  = cfg.auto_recover_enable && all_good && (dt_latch >= cfg.recovery_delay);

    always_comb begin
        logic [3:0] rsn;
        rsn = (ffs_pkg::cmd_t'(in_word.command) == ffs_pkg::CMD_TRIGGER) ?
              in_word.trigger_reason : fail_reason;
        latch_new.latched    = 1'b1;
        latch_new.reason     = rsn;
        latch_new.action     = ffs_pkg::action_for(rsn);
        latch_new.reboot     = ffs_pkg::needs_reboot(rsn);
        latch_new.latch_time = in_word.now_ms;
    end

    always_comb begin
        unlatched            = state;
        unlatched.latched    = 1'b0;
        unlatched.reason     = ffs_pkg::RSN_NONE;
        unlatched.action     = ffs_pkg::ACT_NONE;
        unlatched.reboot     = 1'b0;
    end

    always_comb begin
        state_next = state;
        unique case (ffs_pkg::cmd_t'(in_word.command))
            ffs_pkg::CMD_UPDATE: begin
                if (state.latched) begin
                    if (recover) state_next = unlatched;
                end else if (fail_reason != ffs_pkg::RSN_NONE) begin
                    state_next = latch_new;
                end
            end
            ffs_pkg::CMD_TRIGGER: begin
                if (!state.latched) state_next = latch_new;
            end
            ffs_pkg::CMD_ACK: begin
                state_next = unlatched;
            end
            ffs_pkg::CMD_CLEAR: begin
                state_next            = unlatched;
                state_next.latch_time = '0;
            end
            default: state_next = state;
        endcase
    end

endmodule

// ===== src/flight_failsafe_supervisor_top.sv =====
// ============================================================================
// flight_failsafe_supervisor_top - flight failsafe supervisor
// Latches the first detected failure (health, resources, phase timeouts)
// with its action, and clears it on acknowledge, force clear or recovery.
// ============================================================================
// One result word comes out for every input word, showing the failsafe
// state after that command. Throughput is one word per clock unless m_ready
// stalls the result: the whole decision (six 32-bit wrap-around
// subtract/compare checks, a priority pick and the action map) sits between
// the input register and the result register, and the latch state updates
// on the same edge the result is loaded, so the next word sees it at once.
// s_ready is high while either register is empty or the result is being
// drained, so a held result blocks the next word only when the input
// register is full. Config registers (index 0..6: launch, apogee,
// stabilize, max flight, servo timeouts, recovery delay, auto-recover
// enable in bit 0) are written with cfg_wr_en and must only be changed
// while no word is in flight; all reset to zero.
// ============================================================================
module flight_failsafe_supervisor_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ffs_pkg::in_word_t               s_data,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output ffs_pkg::out_word_t              m_data,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    ffs_pkg::cfg_t      cfg;
    ffs_pkg::in_word_t  in_data_reg;
    logic               in_valid_reg;
    ffs_pkg::fs_state_t state_reg, state_next;
    ffs_pkg::out_word_t out_data_reg, out_data_next;
    logic               out_valid_reg;
    logic               out_free, advance;

    ffs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // result register can take a word if empty or being read this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    ffs_eval u_eval (
        .in_word    (in_data_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next)
    );

    // latch state commits together with the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        out_data_next.failsafe_active = state_next.latched;
        out_data_next.active_reason   = state_next.reason;
        out_data_next.active_action   = state_next.action;
        out_data_next.reboot_required = state_next.reboot;
        // trigger time reads zero while nothing is latched
        out_data_next.trigger_time    = state_next.latched ? state_next.latch_time : '0;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/ffs_checker.sv =====
// ============================================================================
// ffs_checker - port-level checks for the failsafe supervisor
// Watches the result channel for consistent latch contents.
// ============================================================================
module ffs_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ffs_pkg::out_word_t              m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // idle latch reports all-zero contents
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.failsafe_active |->
            m_data.active_reason == ffs_pkg::RSN_NONE &&
            m_data.active_action == ffs_pkg::ACT_NONE &&
            !m_data.reboot_required && m_data.trigger_time == '0)
        else $error("idle result carries latch contents");

    // active latch: action follows the fixed map
    a_action_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.failsafe_active |->
            m_data.active_action == ffs_pkg::action_for(m_data.active_reason))
        else $error("action does not match reason");

    // active latch: reboot flag only for memory, cpu and watchdog reasons
    a_reboot_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.failsafe_active |->
            m_data.reboot_required == ffs_pkg::needs_reboot(m_data.active_reason))
        else $error("reboot flag does not match reason");

endmodule

bind flight_failsafe_supervisor_top ffs_checker u_ffs_checker (.*);
